// ===== src/msx7_pkg.sv =====
// Shared types and constants for the SysEx 7-bit unpacker.
// Holds the input and result transaction structs and the event codes.
// No dependencies.
package msx7_pkg;

    localparam logic [7:0] REALTIME_MIN = 8'hF8;
    localparam logic [7:0] END_OF_EX    = 8'hF7;

    localparam int SUM_W      = 16;
    localparam int CHECKSUM_W = 14;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_END     = 2'd1;
    localparam logic [1:0] EV_ABORT   = 2'd2;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       frame_start;
        logic       payload_last;
    } in_item_t;

    typedef struct packed {
        logic                  data_valid;
        logic [7:0]            data_byte;
        logic [1:0]            event_code;
        logic                  checksum_valid;
        logic [CHECKSUM_W-1:0] checksum;
    } out_item_t;

endpackage

// ===== src/midi_sysex_7bit_unpack.sv =====
// Top level of the SysEx 8-to-7 bit unpacker: input register feeding the decoder.
// Depends on msx7_pkg, msx7_in_stage and msx7_decode.
//
// Accepts one MIDI byte per cycle while in_stall is low and returns at most
// one result per byte: the byte passes the input register, is decoded
// against the group position, top-bit and checksum registers, and lands in the
// result register. Realtime bytes (0xF8 and up) take their cycle and give no
// result. Status byte 0xF7 reports end of message, any other status byte an
// abort; both clear the decoder. The input register lets a new byte enter
// while a finished result waits; throughput stays one byte per cycle as long
// as the output is not stalled.
module midi_sysex_7bit_unpack
    import msx7_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic     stage_valid;
    logic     stage_take;
    in_item_t stage_item;

    msx7_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .stage_take  (stage_take)
    );

    msx7_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .stage_take  (stage_take),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_item    (out_item)
    );

endmodule

// ===== src/msx7_in_stage.sv =====
// Input register of the SysEx 7-bit unpacker.
// Captures one input transaction and holds it until the decoder takes it.
// Depends on msx7_pkg.
module msx7_in_stage
    import msx7_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    output logic     stage_valid,
    output in_item_t stage_item,
    input  logic     stage_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // Hold while the decoder cannot take the registered transaction.
    assign in_stall   = valid_reg && !stage_take;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// ===== src/msx7_decode.sv =====
// Decoder state and result register of the SysEx 7-bit unpacker.
// Restores bit 7 of payload bytes, keeps the running checksum, flags status bytes.
// Depends on msx7_pkg.
module msx7_decode
    import msx7_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      stage_valid,
    input  in_item_t  stage_item,
    output logic      stage_take,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [2:0]       group_pos_reg;
    logic [2:0]       group_pos_next;
    logic [7:0]       top_bits_reg;
    logic [7:0]       top_bits_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    out_item_t        out_item_reg;
    out_item_t        result;
    logic             has_result;

    logic [2:0]       pos_eff;
    logic [7:0]       top_eff;
    logic [SUM_W-1:0] sum_eff;
    logic [SUM_W-1:0] sum_add;
    logic [7:0]       b;
    logic             last;

    // Advance when the result register is empty or being drained.
    assign stage_take = stage_valid && (!out_valid_reg || !out_stall);

    assign b       = stage_item.midi_byte;
    assign last    = stage_item.payload_last;
    assign pos_eff = stage_item.frame_start ? 3'd0 : group_pos_reg;
    assign top_eff = stage_item.frame_start ? 8'd0 : top_bits_reg;
    assign sum_eff = stage_item.frame_start ? '0 : sum_reg;
    assign sum_add = sum_eff + {{(SUM_W-8){1'b0}}, b};

    always_comb
    begin
        group_pos_next = pos_eff;
        top_bits_next  = top_eff;
        sum_next       = sum_eff;
        has_result     = 1'b0;
        result         = '0;
        if (b >= REALTIME_MIN)
        begin
            // Drop realtime bytes; a frame start still clears.
            has_result = 1'b0;
        end
        else if (b[7])
        begin
            has_result        = 1'b1;
            result.event_code = (b == END_OF_EX) ? EV_END : EV_ABORT;
            group_pos_next    = 3'd0;
            top_bits_next     = 8'd0;
            sum_next          = '0;
        end
        else
        begin
            has_result            = 1'b1;
            result.event_code     = EV_PAYLOAD;
            sum_next              = sum_add;
            if (pos_eff == 3'd0)
            begin
                top_bits_next = {b[6:0], 1'b0};
            end
            else
            begin
                result.data_valid = 1'b1;
                result.data_byte  = {top_eff[7], b[6:0]};
                top_bits_next     = {top_eff[6:0], 1'b0};
            end
            group_pos_next        = pos_eff + 3'd1;
            result.checksum_valid = last;
            result.checksum       = last ? sum_add[CHECKSUM_W-1:0] : '0;
            if (last)
            begin
                group_pos_next = 3'd0;
                top_bits_next  = 8'd0;
                sum_next       = '0;
            end
        end
    end

    always_comb
    begin
        if (stage_take)
        begin
            out_valid_next = has_result;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg <= 3'd0;
            top_bits_reg  <= 8'd0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (stage_take)
            begin
                group_pos_reg <= group_pos_next;
                top_bits_reg  <= top_bits_next;
                sum_reg       <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_take && has_result)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for midi_sysex_7bit_unpack, driven through its valid/stall channels.
// Predicts every result with a scoreboard class and compares accepted transactions in order.
// Depends on msx7_pkg and the midi_sysex_7bit_unpack RTL.
module testbench
    import msx7_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] STATUS_MIN = 8'h80;
    localparam logic [7:0] ABORT_MAX  = 8'hF6;
    localparam logic [7:0] DATA_MAX   = 8'h7F;

    class unpack_scoreboard;
        out_item_t   awaited_results[$];
        int unsigned failures;
        logic [2:0]  group_pos;
        logic [7:0]  top_bits;
        logic [15:0] byte_sum;

        function new();
            failures = 0;
            restart();
        endfunction

        function void restart();
            group_pos = '0;
            top_bits  = '0;
            byte_sum  = '0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        // Advance the decoder state for one accepted input transaction.
        function void note_byte(in_item_t it);
            out_item_t res;
            res = '0;
            if (it.frame_start)
                restart();
            if (it.midi_byte >= REALTIME_MIN)
                return;
            if (it.midi_byte[7])
            begin
                res.event_code = (it.midi_byte == END_OF_EX) ? EV_END : EV_ABORT;
                restart();
            end
            else
            begin
                byte_sum = byte_sum + 16'(it.midi_byte);
                if (group_pos == 3'd0)
                    top_bits = {it.midi_byte[6:0], 1'b0};
                else
                begin
                    res.data_valid = 1'b1;
                    res.data_byte  = {top_bits[7], it.midi_byte[6:0]};
                    top_bits       = {top_bits[6:0], 1'b0};
                end
                group_pos      = group_pos + 3'd1;
                res.event_code = EV_PAYLOAD;
                if (it.payload_last)
                begin
                    res.checksum_valid = 1'b1;
                    res.checksum       = byte_sum[CHECKSUM_W-1:0];
                    restart();
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (awaited_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result, expected none, got valid=%0b byte=%h ev=%0d",
                         $time, got.data_valid, got.data_byte, got.event_code);
                return;
            end
            exp = awaited_results.pop_front();
            if (got !== exp)
            begin
                failures++;
                $display("%0t: mismatch expected valid=%0b byte=%h ev=%0d csum_valid=%0b csum=%h",
                         $time, exp.data_valid, exp.data_byte, exp.event_code,
                         exp.checksum_valid, exp.checksum);
                $display("%0t:              got valid=%0b byte=%h ev=%0d csum_valid=%0b csum=%h",
                         $time, got.data_valid, got.data_byte, got.event_code,
                         got.checksum_valid, got.checksum);
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    unpack_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;

    midi_sysex_7bit_unpack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_byte(in_item);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_item);
    end

    function automatic in_item_t make_item(logic [7:0] b, logic s, logic l);
        in_item_t it;
        it.midi_byte    = b;
        it.frame_start  = s;
        it.payload_last = l;
        return it;
    endfunction

    // Hold the transaction until the block takes it; idle first at the sender's rate.
    task automatic send_byte(in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        if (it.midi_byte < REALTIME_MIN)
            items_sent++;
    endtask

    task automatic send_status(logic [7:0] b);
        send_byte(make_item(b, 1'($urandom_range(1)), 1'($urandom_range(1))));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Mostly well-formed frames with random content; the rest is raw noise.
    task automatic send_frame();
        int len;
        int term;
        in_item_t it;
        if ($urandom_range(99) >= 85)
        begin
            repeat ($urandom_range(1, 6))
            begin
                it.midi_byte    = 8'($urandom_range(255));
                it.frame_start  = 1'($urandom_range(1));
                it.payload_last = 1'($urandom_range(1));
                send_byte(it);
            end
        end
        else
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < 4)
                    send_status(8'($urandom_range(REALTIME_MIN, 8'hFF)));
                it.midi_byte    = 8'($urandom_range(DATA_MAX));
                it.frame_start  = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
                it.payload_last = (i == len - 1) ? ($urandom_range(4) != 0)
                                                 : ($urandom_range(49) == 0);
                send_byte(it);
            end
            term = $urandom_range(99);
            if (term < 70)
                send_status(END_OF_EX);
            else if (term < 85)
                send_status(8'($urandom_range(STATUS_MIN, ABORT_MAX)));
        end
    endtask

    initial
    begin
        in_item_t directed[$];
        int phase_send[3];
        int phase_recv[3];
        int phase_end[3];

        phase_send = '{29, 67, 0};
        phase_recv = '{67, 29, 0};
        phase_end  = '{200, 400, 950};

        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full group with all top bits set, a realtime byte inside it
        directed.push_back(make_item(8'h7F, 1'b1, 1'b0));
        directed.push_back(make_item(8'h00, 1'b0, 1'b0));
        directed.push_back(make_item(8'h7F, 1'b0, 1'b0));
        directed.push_back(make_item(8'hF8, 1'b0, 1'b1));
        directed.push_back(make_item(8'h55, 1'b0, 1'b0));
        directed.push_back(make_item(8'h2A, 1'b0, 1'b0));
        directed.push_back(make_item(8'h01, 1'b0, 1'b0));
        directed.push_back(make_item(8'h40, 1'b0, 1'b0));
        directed.push_back(make_item(8'h7E, 1'b0, 1'b0));
        // next group, checksum on a data byte, then on a leading byte
        directed.push_back(make_item(8'h00, 1'b0, 1'b0));
        directed.push_back(make_item(8'h7F, 1'b0, 1'b1));
        directed.push_back(make_item(8'h2B, 1'b0, 1'b1));
        // realtime byte that still clears the decoder
        directed.push_back(make_item(8'h10, 1'b0, 1'b0));
        directed.push_back(make_item(8'hFF, 1'b1, 1'b0));
        directed.push_back(make_item(8'h33, 1'b0, 1'b0));
        directed.push_back(make_item(8'hF7, 1'b0, 1'b1));
        directed.push_back(make_item(8'h41, 1'b0, 1'b0));
        directed.push_back(make_item(8'h80, 1'b0, 1'b0));
        directed.push_back(make_item(8'h00, 1'b1, 1'b0));
        directed.push_back(make_item(8'hF6, 1'b1, 1'b1));
        directed.push_back(make_item(8'hF0, 1'b0, 1'b0));
        directed.push_back(make_item(8'hFE, 1'b0, 1'b1));
        directed.push_back(make_item(8'h7F, 1'b1, 1'b1));

        send_idle_pct = phase_send[0];
        recv_idle_pct = phase_recv[0];
        foreach (directed[i])
            send_byte(directed[i]);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = phase_send[p];
            recv_idle_pct = phase_recv[p];
            // long frame pushes the running sum past 16 bits
            if (p == 2)
                for (int i = 0; i < 530; i++)
                    send_byte(make_item(8'h7C | 8'($urandom_range(3)), i == 0, i == 529));
            while (items_sent < phase_end[p])
                send_frame();
            drain();
        end

        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/msx7_pkg.sv
src/msx7_in_stage.sv
src/msx7_decode.sv
src/midi_sysex_7bit_unpack.sv
sim/testbench.sv
